[sv/psdf_pkg.sv]
// psdf_pkg: shared sizes, entry type and sequencer states for the pareto frontier filter
// used by psdf_cmp and pareto_subset_dominance_frontier; no dependencies
`default_nettype none

package psdf_pkg;

   // table and field sizes
   localparam int TABLE_DEPTH = 64;
   localparam int NODE_COUNT  = 32;
   localparam int KEY_WIDTH   = 32;

   localparam int IDX_W   = $clog2(TABLE_DEPTH);
   localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRY_W = KEY_WIDTH + NODE_COUNT;

   // request and response field layout
   localparam int FIELD_W    = 32;
   localparam int REQ_DATA_W = 2 * FIELD_W;
   localparam int OUT_CNT_W  = 7;
   localparam int RSP_DATA_W = 16;

   // command codes carried on req_tuser
   localparam logic CMD_CHECK  = 1'b0;
   localparam logic CMD_INSERT = 1'b1;

   // one stored label
   typedef struct packed {
      logic [KEY_WIDTH-1:0]  cost;
      logic [NODE_COUNT-1:0] nodes;
   } entry_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPEND,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

[sv/psdf_ram.sv]
// psdf_ram: generic single write, single read port ram with registered read data
// no dependencies
`default_nettype none

module psdf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

[sv/psdf_cmp.sv]
// psdf_cmp: shared dominance compare of one stored entry against the current request
// depends on psdf_pkg
`default_nettype none

module psdf_cmp (
   input  wire logic                cmd,
   input  wire psdf_pkg::entry_type query,
   input  wire psdf_pkg::entry_type stored,
   output logic                     hit
);

   logic key_le;
   logic key_ge;
   logic query_in_stored;
   logic stored_in_query;

   // key order and subset tests in both directions
   always_comb begin
      key_le          = stored.cost <= query.cost;
      key_ge          = stored.cost >= query.cost;
      query_in_stored = (query.nodes & ~stored.nodes) == '0;
      stored_in_query = (stored.nodes & ~query.nodes) == '0;
   end

   // check: stored entry dominates query; insert: stored entry is dominated
   always_comb begin
      unique case (cmd)
         psdf_pkg::CMD_INSERT: hit = key_ge && stored_in_query;
         default:              hit = key_le && query_in_stored;
      endcase
   end

endmodule

`default_nettype wire

[sv/pareto_subset_dominance_frontier.sv]
// pareto_subset_dominance_frontier: top level with sequencer, counters and response register
// depends on psdf_pkg, psdf_ram, psdf_cmp
//
//  channel | direction | tdata fields (lsb up)                       | tuser
//  req     | in        | cost_key[31:0], visited_set[63:32]          | command
//  rsp     | out       | dominated[0], removed_count[7:1],           | none
//          |           | table_full[8], occupancy[15:9]              |
//
// a check runs from one accept to the next through the idle accept cycle, one ram read per
// stored entry, the last compare, the scan end and the response load; an insert adds the
// append write
// reset clears the entry count and the handshake state; ram contents need no clearing
// req_tready is high only while idle; a response not yet taken holds the next finish
`default_nettype none

module pareto_subset_dominance_frontier (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [psdf_pkg::REQ_DATA_W-1:0]   req_tdata,  // cost_key, visited_set
   input  wire logic                              req_tuser,  // command
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [psdf_pkg::RSP_DATA_W-1:0]   rsp_tdata   // dominated, removed_count,
                                                              // table_full, occupancy
);

   localparam int CW = psdf_pkg::CNT_W;
   localparam int IW = psdf_pkg::IDX_W;

   psdf_pkg::state_type state_ff, state_in;

   logic                          cmd_ff, cmd_in;
   psdf_pkg::entry_type           query_ff, query_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [CW-1:0]                 idx_ff, idx_in;
   logic [CW-1:0]                 keep_ff, keep_in;
   logic [CW-1:0]                 removed_ff, removed_in;
   logic                          dom_ff, dom_in;
   logic                          full_ff, full_in;
   logic                          data_vld_ff, data_vld_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [psdf_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                          req_accept;
   logic                          issue;
   logic                          scan_done;
   logic                          rsp_free;
   logic                          room;
   logic                          hit;

   logic                          wr_en;
   logic [IW-1:0]                 wr_addr;
   psdf_pkg::entry_type           wr_data;
   logic [IW-1:0]                 rd_addr;
   logic [psdf_pkg::ENTRY_W-1:0]  rd_data;

   // entry storage
   psdf_ram #(
      .WIDTH(psdf_pkg::ENTRY_W),
      .DEPTH(psdf_pkg::TABLE_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // shared compare unit
   psdf_cmp u_cmp (
      .cmd   (cmd_ff),
      .query (query_ff),
      .stored(psdf_pkg::entry_type'(rd_data)),
      .hit   (hit)
   );

   // status terms
   always_comb begin
      req_accept = req_tvalid && req_tready;
      issue      = (state_ff == psdf_pkg::ST_SCAN) && (idx_ff < count_ff);
      scan_done  = (idx_ff == count_ff) && !data_vld_ff;
      rsp_free   = !rsp_valid_ff || rsp_tready;
      room       = keep_ff < CW'(psdf_pkg::TABLE_DEPTH);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         psdf_pkg::ST_IDLE: begin
            if (req_accept) state_in = psdf_pkg::ST_SCAN;
         end
         psdf_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = (cmd_ff == psdf_pkg::CMD_INSERT) ? psdf_pkg::ST_APPEND
                                                           : psdf_pkg::ST_RESP;
            end
         end
         psdf_pkg::ST_APPEND: state_in = psdf_pkg::ST_RESP;
         psdf_pkg::ST_RESP: begin
            if (rsp_free) state_in = psdf_pkg::ST_IDLE;
         end
         default: state_in = psdf_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs: handshake and ram ports
   always_comb begin
      req_tready = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = keep_ff[IW-1:0];
      wr_data    = psdf_pkg::entry_type'(rd_data);
      rd_addr    = idx_ff[IW-1:0];
      unique case (state_ff)
         psdf_pkg::ST_IDLE: req_tready = 1'b1;
         psdf_pkg::ST_SCAN: begin
            // compact survivors toward slot zero
            wr_en = data_vld_ff && (cmd_ff == psdf_pkg::CMD_INSERT) && !hit;
         end
         psdf_pkg::ST_APPEND: begin
            wr_en   = room;
            wr_data = query_ff;
         end
         psdf_pkg::ST_RESP: ;
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      cmd_in       = cmd_ff;
      query_in     = query_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      keep_in      = keep_ff;
      removed_in   = removed_ff;
      dom_in       = dom_ff;
      full_in      = full_ff;
      data_vld_in  = issue;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      // latch a new request
      if (req_accept) begin
         cmd_in         = req_tuser;
         query_in.cost  = psdf_pkg::KEY_WIDTH'(req_tdata[psdf_pkg::FIELD_W-1:0]);
         query_in.nodes = psdf_pkg::NODE_COUNT'(
                             req_tdata[psdf_pkg::REQ_DATA_W-1:psdf_pkg::FIELD_W]);
         idx_in         = '0;
         keep_in        = '0;
         removed_in     = '0;
         dom_in         = 1'b0;
         full_in        = 1'b0;
      end

      // walk the table
      if (issue) idx_in = idx_ff + CW'(1);
      if ((state_ff == psdf_pkg::ST_SCAN) && data_vld_ff) begin
         if (hit) begin
            if (cmd_ff == psdf_pkg::CMD_INSERT) removed_in = removed_ff + CW'(1);
            else                                dom_in     = 1'b1;
         end else if (cmd_ff == psdf_pkg::CMD_INSERT) begin
            keep_in = keep_ff + CW'(1);
         end
      end

      // append or drop the new entry
      if (state_ff == psdf_pkg::ST_APPEND) begin
         if (room) begin
            count_in = keep_ff + CW'(1);
         end else begin
            count_in = keep_ff;
            full_in  = 1'b1;
         end
      end

      // load the response register
      if ((state_ff == psdf_pkg::ST_RESP) && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {psdf_pkg::OUT_CNT_W'(count_ff), full_ff,
                         psdf_pkg::OUT_CNT_W'(removed_ff), dom_ff};
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= psdf_pkg::ST_IDLE;
         count_ff     <= '0;
         data_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         data_vld_ff  <= data_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      query_ff    <= query_in;
      idx_ff      <= idx_in;
      keep_ff     <= keep_in;
      removed_ff  <= removed_in;
      dom_ff      <= dom_in;
      full_ff     <= full_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // every compared entry of an insert is either kept or removed, none skipped
   a_scan_accounting: assert property (@(posedge clock) disable iff (reset)
      (state_ff == psdf_pkg::ST_SCAN && data_vld_ff && cmd_ff == psdf_pkg::CMD_INSERT) |->
         (keep_ff + removed_ff) == (idx_ff - CW'(1)))
      else $error("scan accounting lost an entry");

   // stored count never exceeds the table
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(psdf_pkg::TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // a check never changes the stored count
   a_check_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == psdf_pkg::ST_SCAN && cmd_ff == psdf_pkg::CMD_CHECK) |=>
         count_ff == $past(count_ff))
      else $error("check request changed the entry count");

   // the table is written only while an insert is in progress
   a_write_on_insert: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (cmd_ff == psdf_pkg::CMD_INSERT &&
                 (state_ff == psdf_pkg::ST_SCAN || state_ff == psdf_pkg::ST_APPEND)))
      else $error("table written outside an insert");
`endif

endmodule

`default_nettype wire
